### rtl/core/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the dense layer unit: opcodes, register
// indexes, field widths and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int VALUE_W    = 16;
    localparam int ACC_W      = 48;
    localparam int ACT_W      = 15;
    localparam int OPCODE_W   = 2;
    localparam int FIDX_W     = 8;
    localparam int NIDX_W     = 4;
    localparam int CFG_W      = 9;
    localparam int CFG_FEAT_W = 9;
    localparam int CFG_NEUR_W = 5;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 24;

    localparam logic [OPCODE_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BIAS    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FEATURE = 2'd2;

    localparam logic REG_FEATURES_IN_USE = 1'b0;
    localparam logic REG_NEURONS_IN_USE  = 1'b1;

    localparam logic [ACT_W-1:0] ACT_MAX = {ACT_W{1'b1}};

    typedef struct packed {
        logic accept;
        logic mac_issue;
        logic out_issue;
        logic out_sum;
        logic out_load;
        logic last;
        logic acc_clear;
    } dlr_cmd_t;

    typedef struct packed {
        logic is_feature;
        logic pipe_busy;
        logic out_free;
    } dlr_sts_t;

endpackage

### rtl/core/dlr_ram.sv
// ----------------------------------------------------------------------------
// dlr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// Controller of the dense layer unit: configuration registers, feature and
// neuron counters, and the state machine sequencing MAC and output passes.
// ----------------------------------------------------------------------------
module dlr_ctrl #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_NEURONS  = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic                                        cfg_addr,
    input  logic [dlr_pkg::CFG_W-1:0]                   cfg_wdata,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  dlr_pkg::dlr_sts_t                           sts,
    output dlr_pkg::dlr_cmd_t                           cmd,
    output logic [(MAX_NEURONS > 1 ? $clog2(MAX_NEURONS) : 1)-1:0]   naddr,
    output logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] faddr
);

    import dlr_pkg::*;

    localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int FCW = $clog2(MAX_FEATURES + 1);
    localparam int NCW = $clog2(MAX_NEURONS + 1);

    localparam int FEAT_RESET = (MAX_FEATURES < 256) ? MAX_FEATURES : 256;
    localparam int NEUR_RESET = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MAC      = 3'd1;
    localparam logic [2:0] ST_DRAIN    = 3'd2;
    localparam logic [2:0] ST_OUT_RD   = 3'd3;
    localparam logic [2:0] ST_OUT_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT_SUM  = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [NCW-1:0] n_reg, n_next;
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic [FCW-1:0] feat_cfg_reg;
    logic [NCW-1:0] neur_cfg_reg;
    logic [FCW-1:0] feat_clamp;
    logic [NCW-1:0] neur_clamp;
    logic [31:0]    feat_wd;
    logic [31:0]    neur_wd;
    logic [NCW-1:0] n_inc;
    logic [FCW-1:0] fcnt_inc;
    logic           n_last;

    always_comb begin
        feat_wd = 32'(cfg_wdata[CFG_FEAT_W-1:0]);
        neur_wd = 32'(cfg_wdata[CFG_NEUR_W-1:0]);
        if (feat_wd == 32'd0) begin
            feat_clamp = FCW'(1);
        end else if (feat_wd > 32'(MAX_FEATURES)) begin
            feat_clamp = FCW'(MAX_FEATURES);
        end else begin
            feat_clamp = FCW'(feat_wd);
        end
        if (neur_wd == 32'd0) begin
            neur_clamp = NCW'(1);
        end else if (neur_wd > 32'(MAX_NEURONS)) begin
            neur_clamp = NCW'(MAX_NEURONS);
        end else begin
            neur_clamp = NCW'(neur_wd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feat_cfg_reg <= FCW'(FEAT_RESET);
            neur_cfg_reg <= NCW'(NEUR_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FEATURES_IN_USE: feat_cfg_reg <= feat_clamp;
                REG_NEURONS_IN_USE:  neur_cfg_reg <= neur_clamp;
                default:             ;
            endcase
        end
    end

    assign n_inc    = n_reg + NCW'(1);
    assign fcnt_inc = fcnt_reg + FCW'(1);
    assign n_last   = (n_inc == neur_cfg_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign naddr    = n_reg[NW-1:0];
    assign faddr    = fcnt_reg[FW-1:0];

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        fcnt_next     = fcnt_reg;
        cmd           = '0;
        cmd.accept    = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && sts.is_feature) begin
                    n_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (n_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    n_next = n_inc;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    if (fcnt_inc >= feat_cfg_reg) begin
                        fcnt_next  = '0;
                        n_next     = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        fcnt_next  = fcnt_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT_RD: begin
                cmd.out_issue = 1'b1;
                state_next    = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                cmd.out_sum = 1'b1;
                state_next  = ST_OUT_SUM;
            end
            ST_OUT_SUM: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.last     = n_last;
                    if (n_last) begin
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        n_next     = n_inc;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            fcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            fcnt_reg  <= fcnt_next;
        end
    end

endmodule

### rtl/core/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// Datapath of the dense layer unit: weight, bias and accumulator memories,
// the shared multiply-accumulate pipeline, bias/ReLU/saturation and the
// output register.
// ----------------------------------------------------------------------------
module dlr_datapath #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_NEURONS  = 16,
    parameter int FRAC_BITS    = 8
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic [dlr_pkg::S_DATA_W-1:0]                s_tdata,
    input  logic [dlr_pkg::OPCODE_W-1:0]                s_tuser,
    input  dlr_pkg::dlr_cmd_t                           cmd,
    output dlr_pkg::dlr_sts_t                           sts,
    input  logic [(MAX_NEURONS > 1 ? $clog2(MAX_NEURONS) : 1)-1:0]   naddr,
    input  logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] faddr,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [dlr_pkg::M_DATA_W-1:0]                m_tdata,
    output logic                                        m_tuser,
    output logic                                        m_tlast
);

    import dlr_pkg::*;

    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int SUM_W = ACC_W + 1;
    localparam int PROD_W = 2 * VALUE_W;

    logic [OPCODE_W-1:0]       op;
    logic [FIDX_W-1:0]         fidx;
    logic [NIDX_W-1:0]         nidx;
    logic [VALUE_W-1:0]        val;
    logic [FW+FIDX_W-1:0]      fidx_wide;
    logic [NW+NIDX_W-1:0]      nidx_wide;
    logic [NW+NIDX_W-1:0]      naddr_wide;
    logic                      fidx_ok;
    logic                      nidx_ok;

    logic                      w_we;
    logic [FW+NW-1:0]          w_waddr;
    logic [FW+NW-1:0]          w_raddr;
    logic [VALUE_W-1:0]        w_rdata;
    logic                      b_we;
    logic [VALUE_W-1:0]        b_rdata;
    logic                      acc_we;
    logic [ACC_W-1:0]          acc_wdata;
    logic [ACC_W-1:0]          acc_rdata;

    logic signed [VALUE_W-1:0] feat_reg;
    logic [MAX_NEURONS-1:0]    acc_vld_reg;
    logic                      s1_go_reg;
    logic                      s1_vld_reg;
    logic [NW-1:0]             s1_n_reg;
    logic                      s2_go_reg;
    logic [NW-1:0]             s2_n_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_hold_reg;
    logic signed [ACC_W-1:0]   acc_cur;
    logic signed [SUM_W-1:0]   bias_al;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]          shifted;
    logic                      sum_pos;
    logic                      over;
    logic [ACT_W-1:0]          act;
    logic                      clip;

    logic                      m_valid_reg;
    logic [NIDX_W-1:0]         out_neuron_reg;
    logic [ACT_W-1:0]          act_reg;
    logic                      clip_reg;
    logic                      last_reg;

    assign op   = s_tuser;
    assign fidx = s_tdata[FIDX_W-1:0];
    assign nidx = s_tdata[FIDX_W+NIDX_W-1:FIDX_W];
    assign val  = s_tdata[FIDX_W+NIDX_W+VALUE_W-1:FIDX_W+NIDX_W];

    assign fidx_wide  = {{FW{1'b0}}, fidx};
    assign nidx_wide  = {{NW{1'b0}}, nidx};
    assign naddr_wide = {{NIDX_W{1'b0}}, naddr};
    assign fidx_ok    = (32'(fidx) < 32'(MAX_FEATURES));
    assign nidx_ok    = (32'(nidx) < 32'(MAX_NEURONS));

    assign w_we    = cmd.accept && (op == OP_WEIGHT) && fidx_ok && nidx_ok;
    assign b_we    = cmd.accept && (op == OP_BIAS) && nidx_ok;
    assign w_waddr = {fidx_wide[FW-1:0], nidx_wide[NW-1:0]};
    assign w_raddr = {faddr, naddr};

    dlr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (1 << (FW + NW))
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (val),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (1 << NW)
    ) u_bias_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (nidx_wide[NW-1:0]),
        .wdata (val),
        .raddr (naddr),
        .rdata (b_rdata)
    );

    dlr_ram #(
        .WIDTH (ACC_W),
        .DEPTH (1 << NW)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (s2_n_reg),
        .wdata (acc_wdata),
        .raddr (naddr),
        .rdata (acc_rdata)
    );

    assign acc_cur   = s1_vld_reg ? $signed(acc_rdata) : '0;
    assign acc_we    = s2_go_reg;
    assign acc_wdata = acc_hold_reg + ACC_W'(prod_reg);
    assign bias_al   = SUM_W'($signed(b_rdata)) <<< FRAC_BITS;

    assign sum_pos = !sum_reg[SUM_W-1] && (sum_reg != '0);
    assign shifted = sum_reg >> FRAC_BITS;
    assign over    = |shifted[SUM_W-1:ACT_W];
    assign act     = !sum_pos ? '0 : (over ? ACT_MAX : shifted[ACT_W-1:0]);
    assign clip    = sum_pos && over;

    always_ff @(posedge aclk) begin
        if (cmd.accept && (op == OP_FEATURE)) begin
            feat_reg <= $signed(val);
        end
        s1_vld_reg   <= acc_vld_reg[naddr];
        s1_n_reg     <= naddr;
        s2_n_reg     <= s1_n_reg;
        prod_reg     <= feat_reg * $signed(w_rdata);
        acc_hold_reg <= acc_cur;
        if (cmd.out_sum) begin
            sum_reg <= SUM_W'(acc_cur) + bias_al;
        end
        if (cmd.out_load) begin
            out_neuron_reg <= naddr_wide[NIDX_W-1:0];
            act_reg        <= act;
            clip_reg       <= clip;
            last_reg       <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_go_reg   <= 1'b0;
            s2_go_reg   <= 1'b0;
            acc_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            s1_go_reg <= cmd.mac_issue;
            s2_go_reg <= s1_go_reg;
            if (cmd.acc_clear) begin
                acc_vld_reg <= '0;
            end else if (s2_go_reg) begin
                acc_vld_reg[s2_n_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_feature = (op == OP_FEATURE);
    assign sts.pipe_busy  = s1_go_reg || s2_go_reg;
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - NIDX_W - ACT_W){1'b0}}, act_reg, out_neuron_reg};
    assign m_tuser  = clip_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/core/dense_layer_relu_unit.sv
// ----------------------------------------------------------------------------
// dense_layer_relu_unit
// Fully connected layer with ReLU in signed fixed point: weight and bias
// loads, per-feature multiply-accumulate, one activation beat per neuron.
// ----------------------------------------------------------------------------
// A weight or bias beat is written as it is accepted. A feature beat occupies
// the block while one shared multiply-accumulate walks the neurons, one weight
// memory read per cycle, followed by a pipeline drain. The last feature of a
// row then takes each neuron result through an accumulator and bias read, a
// sum and a saturation, stretched by any back-pressure on the result channel.
// No input beat is taken while a feature or a row end is in progress; a
// finished result may sit in the output register while the next beat is
// accepted. Weights and biases read as undefined until written.
module dense_layer_relu_unit #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_NEURONS  = 16,
    parameter int FRAC_BITS    = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_addr,
    input  logic [dlr_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // feature_index[7:0], neuron_index[11:8], value[27:12], zero[31:28]
    input  logic [dlr_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [dlr_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_neuron[3:0], activation[18:4], zero[23:19]
    output logic [dlr_pkg::M_DATA_W-1:0]   m_tdata,
    // clipped[0]
    output logic                           m_tuser,
    output logic                           m_tlast
);

    import dlr_pkg::*;

    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;

    dlr_cmd_t     cmd;
    dlr_sts_t     sts;
    logic [NW-1:0] naddr;
    logic [FW-1:0] faddr;

    dlr_ctrl #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_NEURONS  (MAX_NEURONS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd),
        .naddr     (naddr),
        .faddr     (faddr)
    );

    dlr_datapath #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_NEURONS  (MAX_NEURONS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .naddr    (naddr),
        .faddr    (faddr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
